>>> design/trd_pkg.sv
// ----------------------------------------------------------------------------
// trd_pkg
// Shared constants, codes and types of the trim range distributor.
// ----------------------------------------------------------------------------
package trd_pkg;

   localparam int MAX_SHAPES = 16;
   localparam int ADDR_W     = (MAX_SHAPES > 1) ? $clog2(MAX_SHAPES) : 1;
   localparam int CNT_W      = $clog2(MAX_SHAPES + 1);

   localparam int LEN_W      = 24;
   localparam int TOT_W      = 30;
   localparam int WIN_W      = 24;
   localparam int IDX_W      = 6;
   localparam int ACT_W      = 2;
   localparam int OFS_W      = 17;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;

   // divider: numerator below den << DIV_Q_W, so DIV_Q_W steps suffice
   localparam int DIV_NUM_W  = 40;
   localparam int DIV_DEN_W  = 24;
   localparam int DIV_Q_W    = 18;
   localparam int DIV_CNT_W  = $clog2(DIV_Q_W + 1);

   typedef enum logic [ACT_W-1:0] {
      ACT_KEEP   = 2'd0,
      ACT_TRIM   = 2'd1,
      ACT_REMOVE = 2'd2
   } action_type;

   localparam logic [CSR_IDX_W-1:0] CSR_TRIM_START = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TRIM_END   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET     = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MODE       = 2'd3;

   typedef struct packed {
      logic done;
   } div_sts_type;

endpackage

>>> design/trd_ram.sv
// ----------------------------------------------------------------------------
// trd_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module trd_ram #(
   parameter int  WIDTH  = 8,
   parameter int  DEPTH  = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/trd_div.sv
// ----------------------------------------------------------------------------
// trd_div
// Restoring divider, one quotient bit per cycle, for numerators known to
// give a quotient of at most DIV_Q_W bits.
// ----------------------------------------------------------------------------
module trd_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [trd_pkg::DIV_NUM_W-1:0] num,
   input  logic [trd_pkg::DIV_DEN_W-1:0] den,
   output trd_pkg::div_sts_type          sts,
   output logic [trd_pkg::DIV_Q_W-1:0]   quo
);

   localparam int NW = trd_pkg::DIV_NUM_W;
   localparam int DW = trd_pkg::DIV_DEN_W;
   localparam int QW = trd_pkg::DIV_Q_W;

   logic [DW-1:0]                 rem_ff;
   logic [DW-1:0]                 rem_in;
   logic [QW-1:0]                 sh_ff;
   logic [QW-1:0]                 sh_in;
   logic [DW-1:0]                 den_ff;
   logic [trd_pkg::DIV_CNT_W-1:0] cnt_ff;
   logic                          busy_ff;
   logic                          done_ff;
   logic [DW:0]                   trial;
   logic [DW:0]                   diff;
   logic                          ge;

   assign trial  = {rem_ff, sh_ff[QW-1]};
   assign diff   = trial - {1'b0, den_ff};
   assign ge     = trial >= {1'b0, den_ff};
   assign rem_in = ge ? diff[DW-1:0] : trial[DW-1:0];
   assign sh_in  = {sh_ff[QW-2:0], ge};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            rem_ff  <= {{(DW-(NW-QW)){1'b0}}, num[NW-1:QW]};
            sh_ff   <= num[QW-1:0];
            den_ff  <= den;
            cnt_ff  <= trd_pkg::DIV_CNT_W'(QW);
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            rem_ff <= rem_in;
            sh_ff  <= sh_in;
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == trd_pkg::DIV_CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign sts.done = done_ff;
   assign quo      = sh_ff;

endmodule

>>> design/trim_range_distributor.sv
// ----------------------------------------------------------------------------
// trim_range_distributor
// Collects shape lengths and, on the last shape, walks the stored lengths to give
// each shape its local trim window, or in simultaneous mode the global window.
// ----------------------------------------------------------------------------
//   channel | direction | handshake            | beat carries
//   req_    | in        | req_valid/req_ready  | shape_length, last_shape
//   rsp_    | out       | rsp_valid/rsp_ready  | index, action, reverse, window, last
//   csr_    | in        | csr_valid/csr_ready  | register index, write data
//
// Loading accepts one beat per cycle. The last beat starts a run: S_OFS, S_OFSW and
// S_GWIN form the offset (shift, reciprocal multiply) and the global window, then
// S_NORM and S_MUL mirror, normalise and scale it in individual mode, S_SIMUL in
// simultaneous. Each trimmed shape then costs read, compare, a division and an
// emit; kept or removed shapes skip the division; simultaneous shapes only emit.
// The lengths sit in one memory with registered read data.
// Reset is synchronous; it clears control state and restores the registers.
// A low rsp_ready holds the walk at the emit step; no beat is lost.
// ----------------------------------------------------------------------------
module trim_range_distributor (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [trd_pkg::LEN_W-1:0]      req_shape_length,
   input  logic                           req_last_shape,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [trd_pkg::IDX_W-1:0]      rsp_shape_index,
   output logic [trd_pkg::ACT_W-1:0]      rsp_action,
   output logic                           rsp_reverse_path,
   output logic signed [trd_pkg::WIN_W-1:0] rsp_window_start,
   output logic signed [trd_pkg::WIN_W-1:0] rsp_window_end,
   output logic                           rsp_last_result,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [trd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [trd_pkg::CSR_DATA_W-1:0] csr_data
);

   localparam int AW = trd_pkg::ADDR_W;
   localparam int CW = trd_pkg::CNT_W;
   localparam int LW = trd_pkg::LEN_W;
   localparam int TW = trd_pkg::TOT_W;
   localparam int WW = trd_pkg::WIN_W;
   localparam int NW = trd_pkg::DIV_NUM_W;
   localparam int QW = trd_pkg::DIV_Q_W;
   localparam int CMP_W = 56;

   typedef enum logic [3:0] {
      S_LOAD, S_OFS, S_OFSW, S_GWIN, S_NORM, S_MUL, S_SIMUL, S_RD, S_CMP, S_DIV,
      S_EMIT
   } state_type;

   state_type state_ff;

   // configuration registers
   logic signed [23:0] trim_start_ff;
   logic signed [23:0] trim_end_ff;
   logic [16:0]        ofs_deg_ff;
   logic               indiv_ff;

   // run state
   logic [CW-1:0]      count_ff;
   logic [TW-1:0]      total_ff;
   logic [TW-1:0]      added_ff;
   logic [CW-1:0]      pos_ff;
   logic               ofs_neg_ff;
   logic [23:0]        ofs_y_ff;
   logic [QW-1:0]      ofs_quo_ff;
   logic [24:0]        gstart_ff;
   logic [24:0]        gend_ff;
   logic               rev_ff;
   logic [15:0]        stlo_ff;
   logic [24:0]        enn_ff;
   logic [CMP_W-1:0]   ts_ff;
   logic [CMP_W-1:0]   te_ff;
   logic               extra_ff;

   // pending result
   trd_pkg::action_type res_act_ff;
   logic                res_rev_ff;
   logic [WW-1:0]       res_ws_ff;
   logic [WW-1:0]       res_we_ff;

   // output register
   logic                rsp_valid_ff;
   logic [trd_pkg::IDX_W-1:0] rsp_index_ff;
   trd_pkg::action_type rsp_act_ff;
   logic                rsp_rev_ff;
   logic [WW-1:0]       rsp_ws_ff;
   logic [WW-1:0]       rsp_we_ff;
   logic                rsp_last_ff;

   // ---------------------------------------------------------------------
   // Handshakes
   // ---------------------------------------------------------------------
   logic req_acc;
   logic slot_free;
   assign req_ready = (state_ff == S_LOAD);
   assign req_acc   = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // ---------------------------------------------------------------------
   // Walk position and memory address; reverse runs walk from the top
   // ---------------------------------------------------------------------
   logic [CW-1:0] last_pos;
   logic [CW-1:0] idx_full;
   logic          at_last;
   assign last_pos = count_ff - 1'b1;
   assign idx_full = rev_ff ? (last_pos - pos_ff) : pos_ff;
   assign at_last  = (pos_ff == last_pos);

   logic          store_room;
   logic [TW-1:0] total_in;
   assign store_room = (count_ff < CW'(trd_pkg::MAX_SHAPES));
   assign total_in   = total_ff + TW'(req_shape_length);

   logic [LW-1:0] rd_len;

   trd_ram #(
      .WIDTH (LW),
      .DEPTH (trd_pkg::MAX_SHAPES)
   ) u_len_ram (
      .clock   (clock),
      .wr_en   (req_acc && store_room),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (req_shape_length),
      .rd_en   (state_ff == S_RD),
      .rd_addr (idx_full[AW-1:0]),
      .rd_data (rd_len)
   );

   // ---------------------------------------------------------------------
   // Offset: floor((deg * 2048 + 360) / 720), negative side via magnitude.
   // Divide by 16 with a shift, then by 45 through a reciprocal: 2^30 / 45
   // rounded up gives the exact quotient for every 24-bit dividend.
   // ---------------------------------------------------------------------
   localparam logic [24:0] RECIP_45 = 25'd23860930;

   logic [28:0] ofs_num;
   logic        ofs_neg;
   logic [28:0] ofs_mag;
   logic [48:0] ofs_prod;
   assign ofs_num  = {ofs_deg_ff[16], ofs_deg_ff, 11'b0} + 29'd360;
   assign ofs_neg  = ofs_num[28];
   assign ofs_mag  = ofs_neg ? (~ofs_num + 29'd720) : ofs_num;
   assign ofs_prod = ofs_y_ff * RECIP_45;

   // ---------------------------------------------------------------------
   // Dividers: unit a gives the window start, unit b the window end
   // ---------------------------------------------------------------------
   trd_pkg::div_sts_type div_a_sts;
   trd_pkg::div_sts_type div_b_sts;
   logic [QW-1:0]        quo_a;
   logic [QW-1:0]        quo_b;
   logic                 div_start;
   logic [NW-1:0]        win_a;
   logic [NW-1:0]        win_b;
   logic                 hit;
   logic                 empty_shape;

   assign div_start = (state_ff == S_CMP) && !empty_shape && hit;

   trd_div u_div_a (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (win_a),
      .den   (rd_len),
      .sts   (div_a_sts),
      .quo   (quo_a)
   );

   trd_div u_div_b (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (win_b),
      .den   (rd_len),
      .sts   (div_b_sts),
      .quo   (quo_b)
   );

   // ---------------------------------------------------------------------
   // Global window after the offset
   // ---------------------------------------------------------------------
   logic [18:0] ofs_q;
   logic [18:0] ofs_val;
   logic [24:0] gstart_in;
   logic [24:0] gend_in;
   assign ofs_q     = {1'b0, ofs_quo_ff};
   assign ofs_val   = ofs_neg_ff ? (~ofs_q + 19'd1) : ofs_q;
   assign gstart_in = {trim_start_ff[23], trim_start_ff} + {{6{ofs_val[18]}}, ofs_val};
   assign gend_in   = {trim_end_ff[23], trim_end_ff} + {{6{ofs_val[18]}}, ofs_val};

   // saturate to 24 bit signed for simultaneous mode
   logic [WW-1:0] sat_start;
   logic [WW-1:0] sat_end;
   assign sat_start = (gstart_ff[24] != gstart_ff[23]) ?
                      (gstart_ff[24] ? 24'h800000 : 24'h7FFFFF) : gstart_ff[23:0];
   assign sat_end   = (gend_ff[24] != gend_ff[23]) ?
                      (gend_ff[24] ? 24'h800000 : 24'h7FFFFF) : gend_ff[23:0];

   // mirror when reversed, then drop the whole part of start
   logic        rev_in;
   logic [25:0] st26;
   logic [25:0] en26;
   logic [25:0] enn26;
   assign rev_in = $signed(gend_ff) < $signed(gstart_ff);
   assign st26   = rev_in ? (26'd65536 - {gstart_ff[24], gstart_ff}) : {gstart_ff[24], gstart_ff};
   assign en26   = rev_in ? (26'd65536 - {gend_ff[24], gend_ff}) : {gend_ff[24], gend_ff};
   assign enn26  = en26 - {st26[25:16], 16'b0};

   logic [45:0] ts_prod;
   logic [54:0] te_prod;
   assign ts_prod = stlo_ff * total_ff;
   assign te_prod = enn_ff * total_ff;

   // ---------------------------------------------------------------------
   // Overlap of the window with the current shape
   // ---------------------------------------------------------------------
   logic [CMP_W-1:0] tot16;
   logic [CMP_W-1:0] s0;
   logic [CMP_W-1:0] l16;
   logic [CMP_W-1:0] s1;
   logic [CMP_W-1:0] e2;
   logic [CMP_W-1:0] xb;
   logic [CMP_W-1:0] a_full;
   logic [CMP_W-1:0] b_raw;
   logic [CMP_W-1:0] b_full;
   logic             wrap;
   logic             h1;
   logic             h2;
   logic             use_ts;
   logic             extra_in;

   assign empty_shape = (rd_len == '0) || (total_ff == '0);
   assign tot16 = {{(CMP_W-TW-16){1'b0}}, total_ff, 16'b0};
   assign s0    = {{(CMP_W-TW-16){1'b0}}, added_ff, 16'b0};
   assign l16   = {{(CMP_W-LW-16){1'b0}}, rd_len, 16'b0};
   assign s1    = s0 + l16;
   assign wrap  = te_ff > tot16;
   assign e2    = te_ff - tot16;
   assign h1    = (ts_ff < s1) && (wrap ? (tot16 > s0) : (te_ff > s0));
   assign h2    = wrap && (e2 > s0);

   always_comb begin
      hit      = h1 || h2;
      use_ts   = h1;
      extra_in = h1 && h2;
      if (!wrap) begin
         xb = te_ff;
      end else if (h2) begin
         xb = e2;
      end else begin
         xb = tot16;
      end
   end

   assign a_full = (use_ts && ts_ff > s0) ? (ts_ff - s0) : '0;
   assign b_raw  = xb - s0;
   assign b_full = (b_raw > l16) ? l16 : b_raw;
   assign win_a  = a_full[NW-1:0];
   assign win_b  = b_full[NW-1:0];

   // ---------------------------------------------------------------------
   // Sequencer, configuration and output register
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_LOAD;
         trim_start_ff <= 24'sd0;
         trim_end_ff   <= 24'sd65536;
         ofs_deg_ff    <= '0;
         indiv_ff      <= 1'b0;
         count_ff      <= '0;
         total_ff      <= '0;
         added_ff      <= '0;
         pos_ff        <= '0;
         rev_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               trd_pkg::CSR_TRIM_START: trim_start_ff <= csr_data;
               trd_pkg::CSR_TRIM_END:   trim_end_ff   <= csr_data;
               trd_pkg::CSR_OFFSET:     ofs_deg_ff    <= csr_data[16:0];
               trd_pkg::CSR_MODE:       indiv_ff      <= csr_data[0];
               default: ;
            endcase
         end

         // drop the beat once taken, unless the emit step refills the slot
         if (rsp_valid_ff && rsp_ready && state_ff != S_EMIT) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            S_LOAD: begin
               if (req_acc) begin
                  if (store_room) begin
                     count_ff <= count_ff + 1'b1;
                     total_ff <= total_in;
                  end
                  if (req_last_shape) begin
                     state_ff <= S_OFS;
                  end
               end
            end
            S_OFS: begin
               ofs_neg_ff <= ofs_neg;
               ofs_y_ff   <= ofs_mag[27:4];
               state_ff   <= S_OFSW;
            end
            S_OFSW: begin
               ofs_quo_ff <= ofs_prod[30 +: QW];
               state_ff   <= S_GWIN;
            end
            S_GWIN: begin
               gstart_ff <= gstart_in;
               gend_ff   <= gend_in;
               pos_ff    <= '0;
               added_ff  <= '0;
               rev_ff    <= 1'b0;
               state_ff  <= indiv_ff ? S_NORM : S_SIMUL;
            end
            S_NORM: begin
               rev_ff   <= rev_in;
               stlo_ff  <= st26[15:0];
               enn_ff   <= enn26[24:0];
               state_ff <= S_MUL;
            end
            S_MUL: begin
               ts_ff    <= CMP_W'(ts_prod);
               te_ff    <= CMP_W'(te_prod);
               state_ff <= S_RD;
            end
            S_SIMUL: begin
               res_act_ff <= trd_pkg::ACT_TRIM;
               res_rev_ff <= 1'b0;
               res_ws_ff  <= sat_start;
               res_we_ff  <= sat_end;
               state_ff   <= S_EMIT;
            end
            S_RD: begin
               state_ff <= S_CMP;
            end
            S_CMP: begin
               res_rev_ff <= 1'b0;
               res_ws_ff  <= '0;
               res_we_ff  <= '0;
               if (empty_shape) begin
                  res_act_ff <= trd_pkg::ACT_KEEP;
                  state_ff   <= S_EMIT;
               end else begin
                  added_ff <= added_ff + TW'(rd_len);
                  extra_ff <= extra_in;
                  if (hit) begin
                     state_ff <= S_DIV;
                  end else begin
                     res_act_ff <= trd_pkg::ACT_REMOVE;
                     state_ff   <= S_EMIT;
                  end
               end
            end
            S_DIV: begin
               if (div_a_sts.done && div_b_sts.done) begin
                  res_act_ff <= trd_pkg::ACT_TRIM;
                  res_rev_ff <= rev_ff;
                  res_ws_ff  <= WW'(quo_a);
                  res_we_ff  <= WW'(quo_b) + (extra_ff ? WW'(65536) : WW'(0));
                  state_ff   <= S_EMIT;
               end
            end
            S_EMIT: begin
               if (slot_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_index_ff <= trd_pkg::IDX_W'(idx_full);
                  rsp_act_ff   <= res_act_ff;
                  rsp_rev_ff   <= res_rev_ff;
                  rsp_ws_ff    <= res_ws_ff;
                  rsp_we_ff    <= res_we_ff;
                  rsp_last_ff  <= at_last;
                  if (at_last) begin
                     count_ff <= '0;
                     total_ff <= '0;
                     state_ff <= S_LOAD;
                  end else begin
                     pos_ff   <= pos_ff + 1'b1;
                     state_ff <= indiv_ff ? S_RD : S_EMIT;
                  end
               end
            end
            default: state_ff <= S_LOAD;
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_shape_index  = rsp_index_ff;
   assign rsp_action       = rsp_act_ff;
   assign rsp_reverse_path = rsp_rev_ff;
   assign rsp_window_start = rsp_ws_ff;
   assign rsp_window_end   = rsp_we_ff;
   assign rsp_last_result  = rsp_last_ff;

endmodule
